[rtl/core/bafd_pkg.sv]
// ----------------------------------------------------------------------------
// bafd_pkg
// Shared types, constants and helpers for the bit aligned flag deframer.
// ----------------------------------------------------------------------------
package bafd_pkg;

	// default frame geometry
	localparam int PAYLOAD_LEN_DEF = 8;
	localparam int SEARCH_LEN_DEF  = 32;

	// preamble byte skipped during the hunt
	localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;

	// register reset values
	localparam logic [7:0] FLAG_BYTE_RST    = 8'h7E;
	localparam logic [7:0] CONFIRM_BYTE_RST = 8'h00;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BYTE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_BYTE = 1'b1;

	// input word
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       start_frame;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] byte_index;
		logic       last;
		logic       status;
		logic       confirm_hit;
	} out_word_t;

	// flag search result
	typedef struct packed {
		logic       found;
		logic [2:0] offset;
	} match_t;

	// byte window of the pair {hi, lo} starting off bits below the top
	function automatic logic [7:0] window_at(input logic [7:0] hi, input logic [7:0] lo,
		input logic [2:0] off);
		logic [15:0] pair;
		pair = {hi, lo} << off;
		return pair[15:8];
	endfunction

endpackage

[rtl/core/bafd_offset_finder.sv]
// ----------------------------------------------------------------------------
// bafd_offset_finder
// Eight parallel window compares against the flag, lowest offset wins.
// ----------------------------------------------------------------------------
module bafd_offset_finder (
	input  logic [7:0]      hi,
	input  logic [7:0]      lo,
	input  logic [7:0]      flag_byte,
	output bafd_pkg::match_t match
);
	import bafd_pkg::*;

	logic [7:0] hit;

	// one compare per bit offset
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			hit[k] = (window_at(hi, lo, 3'(k)) == flag_byte);
		end
	end

	// preamble pairs never match, otherwise lowest offset
	always_comb begin
		match.found  = 1'b0;
		match.offset = 3'd0;
		if (hi != PREAMBLE_BYTE && lo != PREAMBLE_BYTE) begin
			for (int k = 7; k >= 0; k--) begin
				if (hit[k]) begin
					match.found  = 1'b1;
					match.offset = 3'(k);
				end
			end
		end
	end

endmodule

[rtl/core/bit_aligned_flag_deframer_unit.sv]
// ----------------------------------------------------------------------------
// bit_aligned_flag_deframer_unit
// Hunts for the flag at any bit offset in consecutive bytes, then emits the
// realigned payload bytes with last and confirmation flags.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+---------------------------
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall    | in_word (rx_byte, start)
//  out     | out       | out_valid / out_stall  | out_word (payload/status)
//
//  one input word per cycle while in_stall is low; a result is registered into
//  the output register, or into the skid entry while that one is held.
//  a two-entry output buffer (output register plus skid) parts the sides;
//  in_stall rises only while the skid entry is full.
//  reset clears all frame state and restores the register defaults.
// ----------------------------------------------------------------------------
module bit_aligned_flag_deframer_unit #(
	parameter int PAYLOAD_LEN = bafd_pkg::PAYLOAD_LEN_DEF,
	parameter int SEARCH_LEN  = bafd_pkg::SEARCH_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bafd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bafd_pkg::in_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bafd_pkg::out_word_t               out_word
);
	import bafd_pkg::*;

	localparam int PC_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
	localparam int SC_W = $clog2(SEARCH_LEN + 1);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_IDLE    = 2'd2
	} phase_t;

	// configuration registers
	logic [7:0] flag_byte_q;
	logic [7:0] confirm_byte_q;

	// frame state
	phase_t          phase_q;
	logic [7:0]      prev_byte_q;
	logic            have_prev_q;
	logic [2:0]      bit_offset_q;
	logic [PC_W-1:0] payload_count_q;
	logic [SC_W-1:0] search_count_q;
	logic            confirm_seen_q;

	// output buffer
	logic      out_valid_q;
	out_word_t out_word_q;
	logic      skid_valid_q;
	out_word_t skid_word_q;

	// next state
	phase_t          phase_d;
	logic [2:0]      bit_offset_d;
	logic [PC_W-1:0] payload_count_d;
	logic [SC_W-1:0] search_count_d;
	logic            confirm_seen_d;
	logic            res_valid;
	out_word_t       res_word;

	// start bit view of the state
	phase_t          eff_phase;
	logic            eff_have;
	logic [2:0]      eff_offset;
	logic [PC_W-1:0] eff_pcount;
	logic [SC_W-1:0] eff_scount;
	logic            eff_confirm;

	logic       accept;
	logic       out_take;
	match_t     match;
	logic [7:0] payload_byte;
	logic       is_last;
	logic       conf_next;

	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_byte_q    <= FLAG_BYTE_RST;
			confirm_byte_q <= CONFIRM_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLAG_BYTE:    flag_byte_q    <= cfg_data;
				CFG_CONFIRM_BYTE: confirm_byte_q <= cfg_data;
			endcase
		end
	end

	bafd_offset_finder u_finder (
		.hi       (prev_byte_q),
		.lo       (in_word.rx_byte),
		.flag_byte(flag_byte_q),
		.match    (match)
	);

	// a start bit restarts the hunt on this very byte
	always_comb begin
		if (in_word.start_frame) begin
			eff_phase   = PH_HUNT;
			eff_have    = 1'b0;
			eff_offset  = 3'd0;
			eff_pcount  = '0;
			eff_scount  = '0;
			eff_confirm = 1'b0;
		end else begin
			eff_phase   = phase_q;
			eff_have    = have_prev_q;
			eff_offset  = bit_offset_q;
			eff_pcount  = payload_count_q;
			eff_scount  = search_count_q;
			eff_confirm = confirm_seen_q;
		end
	end

	assign payload_byte = window_at(prev_byte_q, in_word.rx_byte, eff_offset);
	assign is_last      = (eff_pcount == PC_W'(PAYLOAD_LEN - 1));
	assign conf_next    = eff_confirm || (payload_byte == confirm_byte_q);

	// per-word frame logic
	always_comb begin
		phase_d         = eff_phase;
		bit_offset_d    = eff_offset;
		payload_count_d = eff_pcount;
		search_count_d  = eff_scount;
		confirm_seen_d  = eff_confirm;
		res_valid       = 1'b0;
		res_word        = '0;
		unique case (eff_phase)
			PH_HUNT: begin
				if (eff_scount < SC_W'(SEARCH_LEN)) begin
					search_count_d = eff_scount + 1'b1;
				end
				if (eff_have && match.found) begin
					bit_offset_d    = match.offset;
					phase_d         = PH_PAYLOAD;
					payload_count_d = '0;
					confirm_seen_d  = 1'b0;
				end else if (search_count_d >= SC_W'(SEARCH_LEN)) begin
					res_valid       = 1'b1;
					res_word.last   = 1'b1;
					res_word.status = 1'b1;
					phase_d         = PH_IDLE;
				end
			end
			PH_PAYLOAD: begin
				confirm_seen_d       = conf_next;
				res_valid            = 1'b1;
				res_word.data_byte   = payload_byte;
				res_word.byte_index  = 3'(eff_pcount);
				res_word.last        = is_last;
				res_word.confirm_hit = is_last && conf_next;
				if (is_last) begin
					phase_d = PH_IDLE;
				end else begin
					payload_count_d = eff_pcount + 1'b1;
				end
			end
			default: begin
				phase_d = eff_phase;
			end
		endcase
	end

	// frame state and output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			prev_byte_q     <= 8'd0;
			have_prev_q     <= 1'b0;
			bit_offset_q    <= 3'd0;
			payload_count_q <= '0;
			search_count_q  <= '0;
			confirm_seen_q  <= 1'b0;
			out_valid_q     <= 1'b0;
			out_word_q      <= '0;
			skid_valid_q    <= 1'b0;
			skid_word_q     <= '0;
		end else begin
			if (accept) begin
				phase_q         <= phase_d;
				prev_byte_q     <= in_word.rx_byte;
				have_prev_q     <= 1'b1;
				bit_offset_q    <= bit_offset_d;
				payload_count_q <= payload_count_d;
				search_count_q  <= search_count_d;
				confirm_seen_q  <= confirm_seen_d;
			end
			if (skid_valid_q) begin
				if (out_take) begin
					out_word_q   <= skid_word_q;
					skid_valid_q <= 1'b0;
				end
			end else if (!out_valid_q || out_take) begin
				out_valid_q <= accept && res_valid;
				if (accept && res_valid) begin
					out_word_q <= res_word;
				end
			end else if (accept && res_valid) begin
				skid_word_q  <= res_word;
				skid_valid_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// skid entry only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a stalled skid entry is kept
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_stall) |=> skid_valid_q)
		else $error("skid entry lost under stall");

	// no-flag status is a last word with zero data
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.status) |->
		(out_word.last && out_word.data_byte == 8'd0 && !out_word.confirm_hit))
		else $error("malformed status word");

	// confirmation is reported on last words only
	a_confirm_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.confirm_hit) |-> out_word.last)
		else $error("confirm_hit on a non-last word");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit aligned flag deframer. Queued radio bytes
// (framed bursts at random bit offsets, cut-off frames and noise) are fed
// through a valid/stall driver. A bench-side copy of the deframer predicts
// every result word, which the monitor checks field by field while both
// sides idle and stall at random. The flag and confirm registers are
// changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import bafd_pkg::*;

	localparam int PAYLOAD_LEN = PAYLOAD_LEN_DEF;
	localparam int SEARCH_LEN  = SEARCH_LEN_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_IDLE    = 2'd2
	} frame_phase_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FLAG_BYTE;
	logic [7:0]           cfg_data  = 8'h00;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_word_t             in_word   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_word;

	bit_aligned_flag_deframer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queues between stimulus, driver, predictor and monitor
	in_word_t  rx_word_q[$];
	out_word_t predicted_out_q[$];

	int fail_count = 0;
	int quiet_cycles = 0;

	// bench copy of the deframer registers and frame state
	logic [7:0]   flag_cfg     = FLAG_BYTE_RST;
	logic [7:0]   confirm_cfg  = CONFIRM_BYTE_RST;
	logic [7:0]   last_rx      = 8'h00;
	logic         have_last    = 1'b0;
	frame_phase_t frame_ph     = PH_HUNT;
	logic [2:0]   locked_off   = 3'd0;
	logic [3:0]   pay_cnt      = 4'd0;
	logic [5:0]   search_cnt   = 6'd0;
	logic         confirm_seen = 1'b0;

	// byte seen off bits below the top of the pair {hi, lo}
	function automatic logic [7:0] bit_window(input logic [7:0] hi, input logic [7:0] lo,
		input logic [2:0] off);
		logic [15:0] pair;
		pair = {hi, lo};
		return pair[15 - off -: 8];
	endfunction

	// pause length: mostly none or short, a few long, with calm stretches
	function automatic int pick_pause(inout int calm_run);
		int r;
		if (calm_run > 0) begin
			calm_run--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_run = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// advance the frame state by one accepted byte and queue its result
	task automatic deframe_predict(input in_word_t w);
		out_word_t  res;
		logic       found;
		logic [2:0] off;
		logic [7:0] b;
		logic       is_last;
		res = '0;
		if (w.start_frame) begin
			frame_ph     = PH_HUNT;
			have_last    = 1'b0;
			search_cnt   = '0;
			pay_cnt      = '0;
			confirm_seen = 1'b0;
			locked_off   = '0;
		end
		case (frame_ph)
			PH_HUNT: begin
				found = 1'b0;
				off   = 3'd0;
				if (search_cnt < SEARCH_LEN)
					search_cnt++;
				// preamble pairs never match; the lowest matching offset wins
				if (have_last && last_rx != PREAMBLE_BYTE && w.rx_byte != PREAMBLE_BYTE) begin
					for (int k = 7; k >= 0; k--) begin
						if (bit_window(last_rx, w.rx_byte, 3'(k)) == flag_cfg) begin
							found = 1'b1;
							off   = 3'(k);
						end
					end
				end
				if (found) begin
					locked_off   = off;
					frame_ph     = PH_PAYLOAD;
					pay_cnt      = '0;
					confirm_seen = 1'b0;
				end else if (search_cnt >= SEARCH_LEN) begin
					res.last   = 1'b1;
					res.status = 1'b1;
					predicted_out_q.push_back(res);
					frame_ph = PH_IDLE;
				end
			end
			PH_PAYLOAD: begin
				b       = bit_window(last_rx, w.rx_byte, locked_off);
				is_last = (pay_cnt + 1 >= PAYLOAD_LEN);
				if (b == confirm_cfg)
					confirm_seen = 1'b1;
				res.data_byte   = b;
				res.byte_index  = pay_cnt[2:0];
				res.last        = is_last;
				res.confirm_hit = is_last & confirm_seen;
				predicted_out_q.push_back(res);
				if (is_last)
					frame_ph = PH_IDLE;
				else
					pay_cnt++;
			end
			default: ;
		endcase
		last_rx   = w.rx_byte;
		have_last = 1'b1;
	endtask

	// input driver
	int send_gap = 0;
	int send_calm = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				deframe_predict(in_word);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (rx_word_q.size() > 0) begin
					in_word  <= rx_word_q.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_pause(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	int recv_hold = 0;
	int recv_calm = 0;
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_out_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: data %h idx %0d last %b status %b hit %b",
							out_word.data_byte, out_word.byte_index, out_word.last,
							out_word.status, out_word.confirm_hit);
				end else begin
					want = predicted_out_q.pop_front();
					if (out_word.data_byte !== want.data_byte
						|| out_word.byte_index !== want.byte_index
						|| out_word.last !== want.last
						|| out_word.status !== want.status
						|| out_word.confirm_hit !== want.confirm_hit) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result mismatch: expected data %h idx %0d last %b status %b",
								" hit %b, got data %h idx %0d last %b status %b hit %b"},
								want.data_byte, want.byte_index, want.last, want.status,
								want.confirm_hit, out_word.data_byte, out_word.byte_index,
								out_word.last, out_word.status, out_word.confirm_hit);
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				out_stall <= 1'b1;
			end else begin
				recv_hold = pick_pause(recv_calm);
				out_stall <= (recv_hold > 0);
				if (recv_hold > 0)
					recv_hold--;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("bit_aligned_flag_deframer_unit test failed");
				$finish;
			end
		end
	end

	// register write, only issued while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FLAG_BYTE)
			flag_cfg = val;
		else
			confirm_cfg = val;
	endtask

	// wait until every byte is taken and every result checked, then settle
	task automatic drain();
		do
			@(posedge clk);
		while (rx_word_q.size() != 0 || in_valid || predicted_out_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic st);
		in_word_t w;
		w.rx_byte     = b;
		w.start_frame = st;
		rx_word_q.push_back(w);
	endtask

	// frame as the radio sends it: preamble, junk, flag, payload, all shifted
	// by off bits, followed by idle bytes
	task automatic queue_frame(input int off, input int n_pre, input int n_junk,
		input int n_pay, input int n_tail);
		logic [7:0]  logical[$];
		logic [7:0]  carry;
		logic [15:0] pair;
		int          r;
		repeat (n_pre) logical.push_back(PREAMBLE_BYTE);
		repeat (n_junk) logical.push_back(8'($urandom_range(0, 255)));
		logical.push_back(flag_cfg);
		repeat (n_pay) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				logical.push_back(confirm_cfg);
			else if (r < 30)
				logical.push_back(8'h00);
			else if (r < 40)
				logical.push_back(8'hFF);
			else
				logical.push_back(8'($urandom_range(0, 255)));
		end
		// closes the window of the last payload byte
		logical.push_back(8'($urandom_range(0, 255)));
		carry = 8'($urandom_range(0, 255));
		foreach (logical[i]) begin
			pair = {carry, logical[i]};
			push_byte(pair[7 + off -: 8], i == 0);
			carry = logical[i];
		end
		repeat (n_tail) push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// random mix of full frames, cut-off frames and noise bursts
	task automatic fill_random(input int n_items);
		int r;
		int len;
		int pick;
		while (rx_word_q.size() < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_frame($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 3),
					PAYLOAD_LEN, $urandom_range(0, 3));
			end else if (r < 85) begin
				queue_frame($urandom_range(0, 7), $urandom_range(0, 2), $urandom_range(0, 2),
					$urandom_range(0, PAYLOAD_LEN - 1), 0);
			end else begin
				len = $urandom_range(1, SEARCH_LEN + 12);
				for (int i = 0; i < len; i++) begin
					pick = $urandom_range(0, 99);
					push_byte(pick < 45 ? 8'h00 : pick < 80 ? 8'hFF : 8'($urandom_range(0, 255)),
						i == 0 && $urandom_range(0, 19) != 0);
				end
			end
		end
	endtask

	// stimulus sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: preamble, flag at offset 0, payload extremes
		// with a confirm hit, idle byte after the frame
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7E, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFE, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h3C, 1'b0);
		push_byte(8'h12, 1'b0);
		// flag at the deepest offset, frame cut short by a new start word
		queue_frame(7, 0, 1, 3, 0);
		fill_random(150);
		drain();

		// register extremes
		write_reg(CFG_FLAG_BYTE, 8'h00);
		write_reg(CFG_CONFIRM_BYTE, 8'hFF);
		fill_random(100);
		drain();

		write_reg(CFG_FLAG_BYTE, 8'hFF);
		write_reg(CFG_CONFIRM_BYTE, 8'h00);
		fill_random(100);
		drain();

		write_reg(CFG_FLAG_BYTE, 8'($urandom_range(0, 255)));
		write_reg(CFG_CONFIRM_BYTE, 8'($urandom_range(0, 255)));
		fill_random(200);
		drain();

		write_reg(CFG_FLAG_BYTE, FLAG_BYTE_RST);
		write_reg(CFG_CONFIRM_BYTE, 8'($urandom_range(0, 255)));
		fill_random(200);
		drain();

		if (fail_count == 0 && predicted_out_q.size() == 0)
			$display("bit_aligned_flag_deframer_unit test passed");
		else
			$display("bit_aligned_flag_deframer_unit test failed");
		$finish;
	end

endmodule
